@@ sv/can_transport_session_receiver_defines.svh @@
// Assertion macros shared by the session receiver modules.
// Included by the controller and the datapath; depends on nothing else.
`ifndef CAN_TRANSPORT_SESSION_RECEIVER_DEFINES_SVH
`define CAN_TRANSPORT_SESSION_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("can_tsr assertion failed");

// Next-cycle implication, disabled during reset.
`define CTSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("can_tsr assertion failed");

// Next-cycle implication that is also checked across reset.
`define CTSR_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("can_tsr assertion failed");

`endif

@@ sv/can_tsr_pkg.sv @@
// Types, constants and helper functions of the CAN transport session receiver.
// Used by every module of the block; depends on nothing.
package can_tsr_pkg;

  // Item widths on the stream channels.
  localparam int unsigned IN_W  = 96;
  localparam int unsigned OUT_W = 144;

  // Frame fields and control codes.
  localparam logic [7:0]  PF_CM      = 8'hEC;
  localparam logic [7:0]  PF_DT      = 8'hEB;
  localparam logic [7:0]  CTRL_RTS   = 8'd16;
  localparam logic [7:0]  CTRL_ABORT = 8'd255;
  localparam logic [28:0] DST_CLEAR  = 29'h1FFF00FF;

  // Configuration register indexes and reset values.
  localparam logic REG_OWN_ADDRESS = 1'b0;
  localparam logic REG_CM_ID_BASE  = 1'b1;
  localparam logic [28:0] CM_ID_RESET = 29'd484179968;

  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_CTS      = 3'd1,
    ACT_ABORTED  = 3'd2,
    ACT_PAYLOAD  = 3'd3,
    ACT_SEQ_ZERO = 3'd4,
    ACT_RANGE    = 3'd5
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture the item and read the peer table
    logic commit;  // write the peer table and load the result register
  } cmd_t;

  // One per-peer table entry.
  typedef struct packed {
    logic [15:0] buffer_bytes;
    logic [7:0]  expected_packets;
    logic [7:0]  packets_seen;
  } peer_rec_t;

  // One result item.
  typedef struct packed {
    action_t     action;
    logic        transfer_done;
    logic [7:0]  peer;
    logic [28:0] cts_frame_id;
    logic [7:0]  cts_window;
    logic [23:0] cts_pgn;
    logic [7:0]  received_count;
    logic [10:0] payload_offset;
    logic [55:0] payload;
  } result_t;

  // Round a byte count up to a multiple of seven, saturating at 16 bits.
  // The remainder uses 8 = 1 (mod 7): octal digits are summed twice.
  function automatic logic [15:0] round_up7(input logic [15:0] size);
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [2:0]  rem;
    logic [16:0] sum;
    s1 = 6'(size[2:0]) + 6'(size[5:3]) + 6'(size[8:6]) + 6'(size[11:9])
       + 6'(size[14:12]) + 6'(size[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    rem = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    sum = (rem == 3'd0) ? {1'b0, size} : 17'(size) + 17'(3'd7 - rem);
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

endpackage

@@ sv/can_tsr_cfg.sv @@
// APB-style configuration registers: own address and CTS frame id template.
// Depends on can_tsr_pkg.
module can_tsr_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [7:0]  own_address,
  output logic [28:0] cm_id_base
);
  import can_tsr_pkg::*;

  logic [7:0]  own_address_r;
  logic [28:0] cm_id_base_r;
  logic        wr_en;
  logic        reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      cm_id_base_r  <= CM_ID_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OWN_ADDRESS: own_address_r <= cfg_pwdata[7:0];
        REG_CM_ID_BASE:  cm_id_base_r  <= cfg_pwdata[28:0];
        default: ;
      endcase
    end
  end

  // Read-back.
  always_comb begin
    case (reg_idx)
      REG_OWN_ADDRESS: cfg_prdata = {24'd0, own_address_r};
      REG_CM_ID_BASE:  cfg_prdata = {3'd0, cm_id_base_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign own_address = own_address_r;
  assign cm_id_base  = cm_id_base_r;

endmodule

@@ sv/can_tsr_ctrl.sv @@
// Controller of the session receiver: item handshake and the two-step
// read-modify-write sequence. Depends on can_tsr_pkg and the assertion header.
`include "can_transport_session_receiver_defines.svh"

module can_tsr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output can_tsr_pkg::cmd_t  cmd
);
  import can_tsr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An item is taken in idle; its result is committed once the output slot is free.
  // No item is taken while reset is held.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.accept    = 1'b0;
    cmd.commit    = 1'b0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = rst_n;
        cmd.accept = in_tvalid && rst_n;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

  // An accepted item is always worked on in the following cycle.
  `CTSR_ASSERT_NXT(a_accept_exec, clk, rst_n, cmd.accept, state_r == ST_EXEC)
  // A committed result is offered on the next cycle.
  `CTSR_ASSERT_NXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_r)
  // Reset leaves the controller idle with no result pending.
  `CTSR_ASSERT_RST(a_reset_idle, clk, !rst_n, state_r == ST_IDLE && !out_valid_r)

endmodule

@@ sv/can_tsr_dp.sv @@
// Datapath of the session receiver: item registers, per-peer table memory,
// session flags, frame decode and the result register.
// Depends on can_tsr_pkg and the assertion header.
`include "can_transport_session_receiver_defines.svh"

module can_tsr_dp #(
  parameter int unsigned PEERS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  can_tsr_pkg::cmd_t             cmd,
  input  logic [can_tsr_pkg::IN_W-1:0]  in_tdata,
  input  logic [7:0]                    own_address,
  input  logic [28:0]                   cm_id_base,
  output can_tsr_pkg::result_t          res
);
  import can_tsr_pkg::*;

  localparam int unsigned PW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam logic [8:0] PEER_LIM = 9'(PEERS);

  // Item registers.
  logic [28:0] id_r;
  logic [7:0]  byte_r [8];

  // Per-peer table and session flags.
  peer_rec_t   mem [PEERS];
  peer_rec_t   rd_rec_r;
  logic [PEERS-1:0] open_r;

  result_t     res_r;

  // Decode.
  logic [7:0]    pf, dst, src;
  logic [PW-1:0] src_idx;
  logic          hit, is_open;
  logic [10:0]   seq_end;
  logic [7:0]    seen_inc;
  logic [7:0]    seen_keep;

  // Table update and result.
  result_t   res_nxt;
  logic      wr_en, set_open, clr_open;
  peer_rec_t wr_rec;

  // Capture the item and read the peer entry at its source address.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_r      <= in_tdata[28:0];
      byte_r[0] <= in_tdata[36:29];
      byte_r[1] <= in_tdata[44:37];
      byte_r[2] <= in_tdata[52:45];
      byte_r[3] <= in_tdata[60:53];
      byte_r[4] <= in_tdata[68:61];
      byte_r[5] <= in_tdata[76:69];
      byte_r[6] <= in_tdata[84:77];
      byte_r[7] <= in_tdata[92:85];
      rd_rec_r  <= mem[in_tdata[PW-1:0]];
    end
  end

  // Write-back of the peer entry.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[src_idx] <= wr_rec;
    end
  end

  // Session flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else if (cmd.commit) begin
      if (set_open) begin
        open_r[src_idx] <= 1'b1;
      end else if (clr_open) begin
        open_r[src_idx] <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign pf      = id_r[23:16];
  assign dst     = id_r[15:8];
  assign src     = id_r[7:0];
  assign src_idx = src[PW-1:0];
  assign hit     = (dst == own_address) && ({1'b0, src} < PEER_LIM);
  assign is_open = open_r[src_idx];
  // End of the packet's bytes in the buffer: sequence * 7.
  assign seq_end   = {byte_r[0], 3'b000} - {3'b000, byte_r[0]};
  assign seen_inc  = rd_rec_r.packets_seen + 8'd1;
  assign seen_keep = is_open ? rd_rec_r.packets_seen : 8'd0;

  // Frame handling.
  always_comb begin
    res_nxt      = '0;
    res_nxt.peer = src;
    wr_en        = 1'b0;
    set_open     = 1'b0;
    clr_open     = 1'b0;
    wr_rec       = rd_rec_r;
    if (hit) begin
      if (pf == PF_CM) begin
        if (byte_r[0] == CTRL_RTS) begin
          // Open or refresh the session and answer with a CTS.
          wr_en                   = 1'b1;
          set_open                = 1'b1;
          wr_rec.buffer_bytes     = round_up7({byte_r[2], byte_r[1]});
          wr_rec.expected_packets = byte_r[3];
          wr_rec.packets_seen     = seen_keep;
          res_nxt.action          = ACT_CTS;
          res_nxt.cts_frame_id    = (cm_id_base & DST_CLEAR) | {13'd0, src, 8'd0};
          res_nxt.cts_window      = byte_r[4];
          res_nxt.cts_pgn         = {byte_r[7], byte_r[6], byte_r[5]};
          res_nxt.received_count  = seen_keep;
        end else if (byte_r[0] == CTRL_ABORT && is_open) begin
          clr_open       = 1'b1;
          res_nxt.action = ACT_ABORTED;
        end
      end else if (pf == PF_DT && is_open) begin
        // Count the packet and hand out its bytes if they fit the buffer.
        wr_en                  = 1'b1;
        wr_rec.packets_seen    = seen_inc;
        res_nxt.received_count = seen_inc;
        if (byte_r[0] == 8'd0) begin
          res_nxt.action = ACT_SEQ_ZERO;
        end else if ({5'd0, seq_end} > rd_rec_r.buffer_bytes) begin
          res_nxt.action = ACT_RANGE;
        end else begin
          res_nxt.action         = ACT_PAYLOAD;
          res_nxt.payload_offset = seq_end - 11'd7;
          res_nxt.payload        = {byte_r[7], byte_r[6], byte_r[5], byte_r[4],
                                    byte_r[3], byte_r[2], byte_r[1]};
          if (seen_inc >= rd_rec_r.expected_packets) begin
            clr_open              = 1'b1;
            res_nxt.transfer_done = 1'b1;
          end
        end
      end
    end
  end

  assign res = res_r;

  // A committed RTS leaves the sender's session open.
  `CTSR_ASSERT_NXT(a_rts_opens, clk, rst_n,
    cmd.commit && res_nxt.action == ACT_CTS, open_r[src_idx])
  // A committed abort or completed transfer leaves the session closed.
  `CTSR_ASSERT_NXT(a_close, clk, rst_n,
    cmd.commit && (res_nxt.action == ACT_ABORTED || res_nxt.transfer_done),
    !open_r[src_idx])
  // Only a delivered payload completes a transfer.
  `CTSR_ASSERT_IMP(a_done_payload, clk, rst_n,
    cmd.commit && res_nxt.transfer_done, res_nxt.action == ACT_PAYLOAD && wr_en)

endmodule

@@ sv/can_transport_session_receiver.sv @@
// Receiver of RTS/CTS transport sessions over 29-bit CAN frames.
// One item on in_ is one received frame; one item on out_ is its result.
// in_tdata carries frame_id and the eight data bytes; out_tuser the action,
// out_tlast the transfer-done flag and out_tdata the result fields.
// The cfg_ port sets the own node address and the CTS frame id template.
// Each item is a read-modify-write of the per-peer table: the entry read is
// registered at acceptance, and the table write and the result register load
// follow at commit; a new item is taken only after that commit.
// A new item is accepted while the previous result still waits on out_.
// When the output is stalled, the next item holds in its second step and
// in_tready stays low until the waiting result is taken.
// Reset clears every session flag at once and leaves no result pending;
// the per-peer counts and sizes are read only for open sessions, so the
// block takes items from the first cycle after reset. Configuration is to be
// written by the user while no item is in flight; the block does not enforce it.
module can_transport_session_receiver #(
  parameter int unsigned PEERS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: frame_id[28:0], byte_0[36:29], byte_1[44:37], byte_2[52:45],
  // byte_3[60:53], byte_4[68:61], byte_5[76:69], byte_6[84:77],
  // byte_7[92:85], zero fill[95:93].
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,
  // out_tdata: peer[7:0], cts_frame_id[36:8], cts_window[44:37],
  // cts_pgn[68:45], received_count[76:69], payload_offset[87:77],
  // payload[143:88].
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,
  // out_tuser: action[2:0].
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import can_tsr_pkg::*;

  cmd_t        cmd;
  result_t     res;
  logic [7:0]  own_address;
  logic [28:0] cm_id_base;

  can_tsr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .own_address (own_address),
    .cm_id_base  (cm_id_base)
  );

  can_tsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  can_tsr_dp #(
    .PEERS (PEERS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .own_address (own_address),
    .cm_id_base  (cm_id_base),
    .res         (res)
  );

  // Result packing onto the output channel.
  assign out_tuser = res.action;
  assign out_tlast = res.transfer_done;
  assign out_tdata = {res.payload, res.payload_offset, res.received_count,
                      res.cts_pgn, res.cts_window, res.cts_frame_id, res.peer};

endmodule

@@ verif/session_result_checker.sv @@
// Checker for the CAN transport session receiver: watches the in_, out_ and cfg_ ports,
// predicts each result from its own copy of the per-peer session table and compares them.
// Depends on can_tsr_pkg for the result layout, the frame codes and the register indexes.
module session_result_checker #(
  parameter int unsigned PEERS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  input  logic [2:0]   out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending
);
  import can_tsr_pkg::*;

  // Per-peer session table, mirrored from the accepted items.
  bit          session_live   [PEERS];
  logic [7:0]  total_due      [PEERS];
  logic [7:0]  frames_counted [PEERS];
  logic [15:0] rounded_size   [PEERS];

  logic [7:0]  own_addr;
  logic [28:0] cts_template;

  result_t outcomes_due [$];
  int      mismatches   = 0;
  int      results_seen = 0;

  // Works out the result of one received frame and updates the session table.
  function automatic result_t session_outcome(input logic [95:0] frame);
    logic [28:0] id;
    logic [7:0]  pf;
    logic [7:0]  dst;
    logic [7:0]  src;
    logic [7:0]  b [8];
    int unsigned size;
    int unsigned seq;
    result_t     r;
    id  = frame[28:0];
    pf  = id[23:16];
    dst = id[15:8];
    src = id[7:0];
    for (int k = 0; k < 8; k++) b[k] = frame[29 + 8 * k +: 8];
    r = '0;
    r.action = ACT_IGNORED;
    r.peer = src;
    if (dst != own_addr || src >= PEERS) return r;

    if (pf == PF_CM) begin
      if (b[0] == CTRL_RTS) begin
        // The buffer size is the requested size rounded up to whole packets.
        size = 32'({b[2], b[1]});
        if (size % 7 != 0) size = size + 7 - size % 7;
        if (size > 16'hFFFF) size = 16'hFFFF;
        if (!session_live[src]) begin
          session_live[src] = 1'b1;
          frames_counted[src] = '0;
        end
        rounded_size[src] = size[15:0];
        total_due[src] = b[3];
        r.action = ACT_CTS;
        r.cts_frame_id = (cts_template & DST_CLEAR) | {13'd0, src, 8'd0};
        r.cts_window = b[4];
        r.cts_pgn = {b[7], b[6], b[5]};
        r.received_count = frames_counted[src];
      end else if (b[0] == CTRL_ABORT && session_live[src]) begin
        session_live[src] = 1'b0;
        r.action = ACT_ABORTED;
      end
    end else if (pf == PF_DT && session_live[src]) begin
      // Every data frame of an open session is counted, whatever its sequence.
      seq = 32'(b[0]);
      frames_counted[src] = frames_counted[src] + 8'd1;
      r.received_count = frames_counted[src];
      if (seq == 0) begin
        r.action = ACT_SEQ_ZERO;
      end else if ((seq - 1) * 7 + 7 > 32'(rounded_size[src])) begin
        r.action = ACT_RANGE;
      end else begin
        r.action = ACT_PAYLOAD;
        r.payload_offset = 11'((seq - 1) * 7);
        r.payload = {b[7], b[6], b[5], b[4], b[3], b[2], b[1]};
        if (frames_counted[src] >= total_due[src]) begin
          session_live[src] = 1'b0;
          r.transfer_done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, field, want, got);
    end
  endtask

  // Results are taken before new items so that an item accepted at the same edge
  // never meets its own result.
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      for (int p = 0; p < PEERS; p++) session_live[p] = 1'b0;
      own_addr = '0;
      cts_template = CM_ID_RESET;
      outcomes_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_OWN_ADDRESS) own_addr = cfg_pwdata[7:0];
        else cts_template = cfg_pwdata[28:0];
      end

      if (out_tvalid && out_tready) begin
        got = '0;
        got.action = action_t'(out_tuser);
        got.transfer_done = out_tlast;
        got.peer = out_tdata[7:0];
        got.cts_frame_id = out_tdata[36:8];
        got.cts_window = out_tdata[44:37];
        got.cts_pgn = out_tdata[68:45];
        got.received_count = out_tdata[76:69];
        got.payload_offset = out_tdata[87:77];
        got.payload = out_tdata[143:88];
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result for peer 0x%0h arrived with no item waiting", got.peer);
        end else begin
          want = outcomes_due.pop_front();
          compare_field("action", 64'(want.action), 64'(out_tuser));
          compare_field("transfer_done", 64'(want.transfer_done), 64'(got.transfer_done));
          compare_field("peer", 64'(want.peer), 64'(got.peer));
          compare_field("cts_frame_id", 64'(want.cts_frame_id), 64'(got.cts_frame_id));
          compare_field("cts_window", 64'(want.cts_window), 64'(got.cts_window));
          compare_field("cts_pgn", 64'(want.cts_pgn), 64'(got.cts_pgn));
          compare_field("received_count", 64'(want.received_count),
                        64'(got.received_count));
          compare_field("payload_offset", 64'(want.payload_offset),
                        64'(got.payload_offset));
          compare_field("payload", 64'(want.payload), 64'(got.payload));
          results_seen++;
        end
      end

      if (in_tvalid && in_tready) outcomes_due.push_back(session_outcome(in_tdata));
    end
    fail_count = mismatches;
    pending = outcomes_due.size();
  end

endmodule

@@ verif/tb.sv @@
// Top of the session receiver testbench: clock, reset, frame stimulus, register writes
// and output back-pressure. Depends on can_tsr_pkg, can_transport_session_receiver and
// session_result_checker, which does all the predicting and comparing.
module tb;
  import can_tsr_pkg::*;

  localparam int unsigned PEERS = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  // Codes the block does not act on.
  localparam logic [7:0] PF_OTHER   = 8'hEA;
  localparam logic [7:0] CTRL_OTHER = 8'd17;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           fail_count;
  int           pending;

  int         in_gap_pct;
  int         out_stall_pct;
  bit         hold_request;
  logic [7:0] node_addr;
  int         cycle_count;
  int         next_seq [256];

  can_transport_session_receiver #(.PEERS(PEERS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  session_result_checker #(.PEERS(PEERS)) result_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame builders; byte_0 sits in the lowest byte of the 64-bit data field.
  function automatic logic [95:0] frame_of(input logic [7:0] pf, input logic [7:0] dst,
                                           input logic [7:0] src, input logic [63:0] bytes);
    return {3'b000, bytes, 5'($urandom), pf, dst, src};
  endfunction

  function automatic logic [63:0] rts_bytes(input logic [15:0] size, input logic [7:0] total,
                                            input logic [7:0] window, input logic [23:0] pgn);
    return {pgn, window, total, size, CTRL_RTS};
  endfunction

  function automatic logic [63:0] data_bytes(input logic [7:0] seq);
    return {32'($urandom), 24'($urandom), seq};
  endfunction

  // Offers one item, with a random gap first, and returns once it is accepted.
  task automatic send_frame(input logic [95:0] frame);
    if ($urandom_range(99) < in_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = frame;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_rts(input logic [7:0] src, input logic [15:0] size,
                          input logic [7:0] total);
    send_frame(frame_of(PF_CM, node_addr, src,
                        rts_bytes(size, total, 8'($urandom), 24'($urandom))));
  endtask

  task automatic send_data(input logic [7:0] src, input logic [7:0] seq);
    send_frame(frame_of(PF_DT, node_addr, src, data_bytes(seq)));
  endtask

  task automatic send_abort(input logic [7:0] src);
    send_frame(frame_of(PF_CM, node_addr, src, {24'($urandom), 32'($urandom), CTRL_ABORT}));
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_node(input logic [7:0] addr);
    write_reg(REG_OWN_ADDRESS, {24'd0, addr});
    node_addr = addr;
  endtask

  task automatic wait_drained;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly well-formed sessions on a few peers, with aborts, stray sequences and noise.
  // Only items addressed to this node with a known code count towards the total.
  task automatic run_traffic(input int count);
    int         counted;
    int         pick;
    int         n;
    logic [7:0] pool [4];
    logic [7:0] p;
    logic [7:0] b0;
    logic [7:0] total;
    logic [15:0] size;
    counted = 0;
    pool[0] = $urandom_range(1) ? 8'd0 : 8'd255;
    for (int k = 1; k < 4; k++) pool[k] = 8'($urandom);
    while (counted < count) begin
      p = pool[$urandom_range(3)];
      pick = $urandom_range(99);
      if (pick < 18) begin
        n = $urandom_range(0, 9);
        total = 8'(n);
        size = (n == 0) ? 16'($urandom_range(0, 6)) : 16'(n * 7 - $urandom_range(0, 6));
        if ($urandom_range(9) == 0) begin
          size = 16'($urandom);
          total = 8'($urandom);
        end
        send_rts(p, size, total);
        next_seq[p] = 1;
        counted++;
      end else if (pick < 70) begin
        b0 = next_seq[p][7:0];
        next_seq[p]++;
        if ($urandom_range(19) == 0) b0 = 8'($urandom);
        send_data(p, b0);
        counted++;
      end else if (pick < 76) begin
        send_abort(p);
        counted++;
      end else if (pick < 82) begin
        send_frame(frame_of($urandom_range(1) ? PF_CM : PF_DT,
                            node_addr ^ 8'($urandom_range(1, 255)), p,
                            {32'($urandom), 32'($urandom)}));
      end else if (pick < 88) begin
        send_frame(frame_of(PF_OTHER - 8'($urandom_range(0, 3)), node_addr, p,
                            {32'($urandom), 32'($urandom)}));
      end else if (pick < 92) begin
        b0 = 8'($urandom);
        if (b0 == CTRL_RTS || b0 == CTRL_ABORT) b0 = CTRL_OTHER;
        send_frame(frame_of(PF_CM, node_addr, p, {24'($urandom), 32'($urandom), b0}));
      end else begin
        send_data(p, 8'($urandom));
        counted++;
      end
    end
  endtask

  // Output back-pressure, with one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] wrap_peer;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_request = 1'b0;
    in_gap_pct = 10;
    out_stall_pct = 49;
    node_addr = '0;
    for (int k = 0; k < 256; k++) next_seq[k] = 1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed cases on the reset configuration (own address zero).
    send_frame(frame_of(PF_CM, 8'd1, 8'd5, rts_bytes(16'd14, 8'd2, 8'hFF, 24'hFFFFFF)));
    send_frame(frame_of(PF_OTHER, node_addr, 8'd5, rts_bytes(16'd14, 8'd2, 8'h0, 24'h0)));
    send_frame(frame_of(PF_CM, node_addr, 8'd5, {56'd0, CTRL_OTHER}));
    send_abort(8'd5);
    send_data(8'd5, 8'd1);
    send_frame(frame_of(PF_CM, node_addr, 8'd5, rts_bytes(16'd20, 8'd3, 8'hFF, 24'hFFFFFF)));
    send_data(8'd5, 8'd0);
    send_data(8'd5, 8'd4);
    // A repeated request keeps the count and refreshes the size and total.
    send_rts(8'd5, 16'd21, 8'd3);
    send_frame(frame_of(PF_DT, node_addr, 8'd5, {56'hFF_FFFF_FFFF_FFFF, 8'd1}));
    send_data(8'd5, 8'd1);
    // Largest size saturates when rounded; a zero total closes on the first payload.
    send_frame(frame_of(PF_CM, node_addr, 8'd255, rts_bytes(16'hFFFF, 8'd0, 8'h00, 24'h0)));
    send_frame(frame_of(PF_DT, 8'd7, 8'd255, data_bytes(8'd1)));
    send_frame(frame_of(PF_DT, node_addr, 8'd255, {56'd0, 8'd255}));
    send_rts(8'd0, 16'd0, 8'd5);
    send_data(8'd0, 8'd1);
    send_data(8'd0, 8'd0);
    send_abort(8'd0);
    send_abort(8'd0);
    send_rts(8'd9, 16'd7, 8'd1);
    send_data(8'd9, 8'd1);
    wait_drained;

    set_node(8'hFF);
    write_reg(REG_CM_ID_BASE, 32'h1FFF_FFFF);
    run_traffic(50);
    wait_drained;

    // The receiver holds off at the start so that the block fills and stalls its input.
    in_gap_pct = 49;
    out_stall_pct = 10;
    set_node(8'($urandom));
    write_reg(REG_CM_ID_BASE, 32'd0);
    hold_request = 1'b1;
    run_traffic(50);
    wait_drained;

    in_gap_pct = 0;
    out_stall_pct = 0;
    set_node(8'($urandom));
    write_reg(REG_CM_ID_BASE, {3'b000, 29'($urandom)});
    run_traffic(50);

    // Enough uncompleted data frames on one session to wrap its packet count.
    wrap_peer = 8'($urandom);
    send_rts(wrap_peer, 16'd7, 8'd255);
    repeat (257) send_data(wrap_peer, $urandom_range(1) ? 8'd0 : 8'($urandom_range(2, 255)));
    send_data(wrap_peer, 8'd1);
    send_abort(wrap_peer);

    wait_drained;
    repeat (5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
